// ----- hdl/assert_macros.svh -----
// Shared assertion macros for the string decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define JSU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define JSU_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/jsu_pkg.sv -----
package jsu_pkg;

	// Queue depth between the decoder front end and the output sequencer
	localparam int JSU_QUEUE_DEPTH = 4;

	// Decoder modes
	typedef enum logic [2:0] {
		M_IDLE    = 3'd0,
		M_STR     = 3'd1,
		M_ESC     = 3'd2,
		M_HEX1    = 3'd3,
		M_PAIR_BS = 3'd4,
		M_PAIR_U  = 3'd5,
		M_HEX2    = 3'd6
	} mode_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	// Error codes
	localparam logic [3:0] ERR_NONE         = 4'd0;
	localparam logic [3:0] ERR_NO_OPEN      = 4'd1;
	localparam logic [3:0] ERR_CTRL_CHAR    = 4'd2;
	localparam logic [3:0] ERR_ESC_CUT      = 4'd3;
	localparam logic [3:0] ERR_BAD_ESC      = 4'd4;
	localparam logic [3:0] ERR_HEX_CUT      = 4'd5;
	localparam logic [3:0] ERR_BAD_HEX      = 4'd6;
	localparam logic [3:0] ERR_NO_PAIR      = 4'd7;
	localparam logic [3:0] ERR_BAD_LOW      = 4'd8;
	localparam logic [3:0] ERR_LONE_LOW     = 4'd9;
	localparam logic [3:0] ERR_UNTERMINATED = 4'd10;

	// Source characters
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// One decoded source byte's worth of results: up to four, last_idx is count - 1
	typedef struct packed {
		kind_t            kind;
		logic [1:0]       last_idx;
		logic [3:0][7:0]  data;
		logic [3:0]       err;
	} job_t;

endpackage

// ----- hdl/jsu_front.sv -----
module jsu_front
	import jsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_end,
	output logic       push,
	output job_t       job
);

	mode_t        mode_q, mode_d;
	logic [1:0]   hexcnt_q, hexcnt_d;
	logic [15:0]  acc_q, acc_d;
	logic [9:0]   hs_q, hs_d;

	logic         accept;
	logic         has_job;
	logic         hex_ok;
	logic [3:0]   hex_val;
	logic [15:0]  acc_new;
	logic         is_high;
	logic         is_low;
	logic [10:0]  plane_sum;
	logic [20:0]  pair_cp;
	logic [20:0]  enc_v;
	logic [1:0]   enc_last;
	logic [3:0][7:0] enc_data;

	assign accept = in_valid && in_ready;

	// Hex digit decode
	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			hex_val = in_byte[3:0];
		end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
		             (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
			hex_val = in_byte[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign acc_new = {acc_q[11:0], hex_val};
	assign is_high = (acc_new[15:10] == 6'b110110);
	assign is_low  = (acc_new[15:10] == 6'b110111);

	// Supplementary code point: 0x10000 + (high << 10) + low offset
	assign plane_sum = {1'b0, hs_q} + 11'd64;
	assign pair_cp   = {plane_sum, acc_new[9:0]};
	assign enc_v     = (mode_q == M_HEX2) ? pair_cp : {5'd0, acc_new};

	// UTF-8 encoder
	always_comb begin
		enc_data = '0;
		if (enc_v <= 21'h7F) begin
			enc_last    = 2'd0;
			enc_data[0] = enc_v[7:0];
		end else if (enc_v <= 21'h7FF) begin
			enc_last    = 2'd1;
			enc_data[0] = {3'b110, enc_v[10:6]};
			enc_data[1] = {2'b10, enc_v[5:0]};
		end else if (enc_v <= 21'hFFFF) begin
			enc_last    = 2'd2;
			enc_data[0] = {4'b1110, enc_v[15:12]};
			enc_data[1] = {2'b10, enc_v[11:6]};
			enc_data[2] = {2'b10, enc_v[5:0]};
		end else begin
			enc_last    = 2'd3;
			enc_data[0] = {5'b11110, enc_v[20:18]};
			enc_data[1] = {2'b10, enc_v[17:12]};
			enc_data[2] = {2'b10, enc_v[11:6]};
			enc_data[3] = {2'b10, enc_v[5:0]};
		end
	end

	// Next state
	always_comb begin
		mode_d   = mode_q;
		hexcnt_d = hexcnt_q;
		acc_d    = acc_q;
		hs_d     = hs_q;
		if (in_end) begin
			mode_d   = M_IDLE;
			hexcnt_d = 2'd0;
			acc_d    = '0;
		end else begin
			unique case (mode_q)
				M_IDLE: begin
					if (in_byte == CH_QUOTE) mode_d = M_STR;
				end
				M_STR: begin
					if (in_byte == CH_QUOTE || in_byte < CH_SPACE) mode_d = M_IDLE;
					else if (in_byte == CH_BSLASH) mode_d = M_ESC;
				end
				M_ESC: begin
					if (in_byte == CH_U) begin
						mode_d   = M_HEX1;
						hexcnt_d = 2'd0;
						acc_d    = '0;
					end else if (in_byte == CH_QUOTE || in_byte == CH_BSLASH ||
					             in_byte == CH_SLASH || in_byte == CH_B ||
					             in_byte == CH_F || in_byte == CH_N ||
					             in_byte == CH_R || in_byte == CH_T) begin
						mode_d = M_STR;
					end else begin
						mode_d = M_IDLE;
					end
				end
				M_HEX1, M_HEX2: begin
					if (!hex_ok) begin
						mode_d   = M_IDLE;
						hexcnt_d = 2'd0;
						acc_d    = '0;
					end else if (hexcnt_q != 2'd3) begin
						hexcnt_d = hexcnt_q + 2'd1;
						acc_d    = acc_new;
					end else begin
						hexcnt_d = 2'd0;
						acc_d    = '0;
						if (mode_q == M_HEX1) begin
							if (is_high) begin
								mode_d = M_PAIR_BS;
								hs_d   = acc_new[9:0];
							end else if (is_low) begin
								mode_d = M_IDLE;
							end else begin
								mode_d = M_STR;
							end
						end else begin
							mode_d = is_low ? M_STR : M_IDLE;
						end
					end
				end
				M_PAIR_BS: begin
					mode_d = (in_byte == CH_BSLASH) ? M_PAIR_U : M_IDLE;
				end
				M_PAIR_U: begin
					if (in_byte == CH_U) begin
						mode_d   = M_HEX2;
						hexcnt_d = 2'd0;
						acc_d    = '0;
					end else begin
						mode_d = M_IDLE;
					end
				end
				default: begin
					mode_d = M_IDLE;
				end
			endcase
		end
	end

	// Result job for the current byte
	always_comb begin
		has_job      = 1'b0;
		job.kind     = KIND_BYTE;
		job.last_idx = 2'd0;
		job.data     = '0;
		job.err      = ERR_NONE;
		if (in_end) begin
			unique case (mode_q)
				M_STR: begin
					has_job = 1'b1; job.kind = KIND_ERROR; job.err = ERR_UNTERMINATED;
				end
				M_ESC: begin
					has_job = 1'b1; job.kind = KIND_ERROR; job.err = ERR_ESC_CUT;
				end
				M_HEX1, M_HEX2: begin
					has_job = 1'b1; job.kind = KIND_ERROR; job.err = ERR_HEX_CUT;
				end
				M_PAIR_BS, M_PAIR_U: begin
					has_job = 1'b1; job.kind = KIND_ERROR; job.err = ERR_NO_PAIR;
				end
				default: begin
					has_job = 1'b0;
				end
			endcase
		end else begin
			unique case (mode_q)
				M_IDLE: begin
					if (in_byte != CH_QUOTE) begin
						has_job = 1'b1; job.kind = KIND_ERROR; job.err = ERR_NO_OPEN;
					end
				end
				M_STR: begin
					if (in_byte == CH_QUOTE) begin
						has_job = 1'b1; job.kind = KIND_CLOSE;
					end else if (in_byte < CH_SPACE) begin
						has_job = 1'b1; job.kind = KIND_ERROR; job.err = ERR_CTRL_CHAR;
					end else if (in_byte != CH_BSLASH) begin
						has_job = 1'b1; job.data[0] = in_byte;
					end
				end
				M_ESC: begin
					has_job = 1'b1;
					case (in_byte)
						CH_QUOTE, CH_BSLASH, CH_SLASH: job.data[0] = in_byte;
						CH_B: job.data[0] = 8'h08;
						CH_F: job.data[0] = 8'h0C;
						CH_N: job.data[0] = 8'h0A;
						CH_R: job.data[0] = 8'h0D;
						CH_T: job.data[0] = 8'h09;
						CH_U: has_job = 1'b0;
						default: begin
							job.kind = KIND_ERROR;
							job.err  = ERR_BAD_ESC;
						end
					endcase
				end
				M_HEX1, M_HEX2: begin
					if (!hex_ok) begin
						has_job = 1'b1; job.kind = KIND_ERROR; job.err = ERR_BAD_HEX;
					end else if (hexcnt_q == 2'd3) begin
						if (mode_q == M_HEX1 && is_low) begin
							has_job = 1'b1; job.kind = KIND_ERROR; job.err = ERR_LONE_LOW;
						end else if (mode_q == M_HEX2 && !is_low) begin
							has_job = 1'b1; job.kind = KIND_ERROR; job.err = ERR_BAD_LOW;
						end else if (!(mode_q == M_HEX1 && is_high)) begin
							has_job      = 1'b1;
							job.last_idx = enc_last;
							job.data     = enc_data;
						end
					end
				end
				M_PAIR_BS: begin
					if (in_byte != CH_BSLASH) begin
						has_job = 1'b1; job.kind = KIND_ERROR; job.err = ERR_NO_PAIR;
					end
				end
				M_PAIR_U: begin
					if (in_byte != CH_U) begin
						has_job = 1'b1; job.kind = KIND_ERROR; job.err = ERR_NO_PAIR;
					end
				end
				default: begin
					has_job = 1'b0;
				end
			endcase
		end
	end

	assign push = accept && has_job;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			hexcnt_q <= 2'd0;
			acc_q    <= '0;
			hs_q     <= '0;
		end else if (accept) begin
			mode_q   <= mode_d;
			hexcnt_q <= hexcnt_d;
			acc_q    <= acc_d;
			hs_q     <= hs_d;
		end
	end

endmodule

// ----- hdl/jsu_fifo.sv -----
`include "assert_macros.svh"

module jsu_fifo
	import jsu_pkg::*;
#(
	parameter int DEPTH = JSU_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	output logic full,
	input  logic pop,
	output logic nonempty,
	output job_t rd_job
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign rd_job   = slot_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= wr_job;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	`JSU_ASSERT(a_count_range, count_q <= CW'(DEPTH), "queue count beyond depth")
	`JSU_ASSERT(a_no_overflow, !(push && full), "push into full queue")
	`JSU_ASSERT(a_no_underflow, !(pop && !nonempty), "pop from empty queue")

endmodule

// ----- hdl/jsu_back.sv -----
`include "assert_macros.svh"

module jsu_back
	import jsu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_nonempty,
	input  job_t        q_job,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	job_t       job_q;
	logic       valid_q;
	logic [1:0] idx_q;
	logic       is_last;
	logic       out_take;

	assign is_last  = (idx_q == job_q.last_idx);
	assign out_take = valid_q && m_tready;
	// Load the next job when the current one is gone or its last result leaves now
	assign pop      = q_nonempty && (!valid_q || (out_take && is_last));

	// Current job and result index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (pop) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (out_take) begin
			if (is_last) valid_q <= 1'b0;
			else idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) job_q <= q_job;
	end

	// Output transaction
	assign m_tvalid = valid_q;
	assign m_tuser  = job_q.kind;
	assign m_tlast  = is_last;
	assign m_tdata  = {4'd0, job_q.err, job_q.data[idx_q]};

	`JSU_ASSERT(a_load_starts_at_zero, pop |=> (valid_q && idx_q == 2'd0),
		"job load did not restart result index")
	`JSU_ASSERT(a_single_result_kinds, (valid_q && job_q.kind != KIND_BYTE) |->
		(job_q.last_idx == 2'd0), "close or error job with several results")
	`JSU_ASSERT(a_drain_idle, (out_take && is_last && !q_nonempty) |=> !valid_q,
		"output stayed valid after last result with queue empty")

endmodule

// ----- hdl/json_string_unescape.sv -----
// Channel  | Dir | tdata                                   | tuser          | tlast
// s_axis   | in  | [7:0] src_byte                          | [0] end_of_text | -
// m_axis   | out | [7:0] out_byte, [11:8] err_code, pad    | [1:0] kind     | last
//
// One source byte is taken per cycle while the result queue has room.
// Each result is its own transaction; a \u escape may give up to four.
// The sequencer drains one job at a time, a result per cycle while m_tready is high.
// With nothing queued, a byte's first result passes the queue and the job register.
// A stalled output fills the queue (QUEUE_DEPTH jobs), then s_tready drops.
// Reset (arst_n low) returns the decoder to waiting for an opening quote.
module json_string_unescape
	import jsu_pkg::*;
#(
	parameter int QUEUE_DEPTH = JSU_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] src_byte
	input  logic        s_tuser,   // [0] end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [11:8] err_code, [15:12] zero
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast
);

	logic q_full;
	logic q_nonempty;
	logic q_push;
	logic q_pop;
	job_t wr_job;
	job_t rd_job;

	assign s_tready = !q_full;

	// Decoder front end
	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_end   (s_tuser),
		.push     (q_push),
		.job      (wr_job)
	);

	// Job queue
	jsu_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_job   (wr_job),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.rd_job   (rd_job)
	);

	// Output sequencer
	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_job      (rd_job),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule
